// File: hw/rtl/sshf_pkg.sv
`timescale 1ns / 1ps

package sshf_pkg;

    localparam int HASH_W = 32;
    localparam int FOLD_W = 6;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 3;

    localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;
    localparam int FOLD_START = 16;
    localparam logic [FOLD_W-1:0] FOLD_RESET = 6'd32;

    typedef logic [HASH_W-1:0] t_hash;
    typedef logic [FOLD_W-1:0] t_fold_bits;

    typedef enum logic [0:0] {
        REG_SEED      = 1'b0,
        REG_FOLD_BITS = 1'b1
    } t_reg_addr;

endpackage

// File: hw/rtl/seeded_string_hash_fold.sv
`timescale 1ns / 1ps
// A last byte passes the input stage register, then its result is registered in the output register.
// Throughput: one byte per cycle when not stalled; the hash feedback holds one constant multiply.
// The input stage stalls only when a last byte waits on a full, stalled output register.
// Reset (synchronous, active low) empties both stages, ends any string in progress,
// and sets seed to 0 and fold_bits to 32.
module seeded_string_hash_fold (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [sshf_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                         i_last,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output sshf_pkg::t_hash              o_full_hash,
    output sshf_pkg::t_hash              o_folded_hash,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sshf_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import sshf_pkg::*;

    t_hash              r_seed;
    t_fold_bits         r_fold_bits;
    logic               r_a_valid;
    logic [BYTE_W-1:0]  r_a_byte;
    logic               r_a_last;
    t_hash              r_hash;
    logic               r_mid;
    logic               r_out_valid;
    t_hash              r_full;
    t_hash              r_folded;

    t_hash      hash_start;
    t_hash      n_hash;
    t_hash      folded;
    logic       a_move;
    logic       in_take;
    logic       cfg_write;
    t_reg_addr  reg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = t_reg_addr'(paddr[2]);

    always_comb begin
        unique case (reg_sel)
            REG_SEED:      prdata = r_seed;
            REG_FOLD_BITS: prdata = {{(32 - FOLD_W){1'b0}}, r_fold_bits};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_fold_bits <= FOLD_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_SEED:      r_seed      <= pwdata;
                REG_FOLD_BITS: r_fold_bits <= pwdata[FOLD_W-1:0];
                default:       ;
            endcase
        end
    end

    // Only a last byte needs room in the output register.
    assign a_move     = r_a_valid && (!r_a_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_a_valid && !a_move;
    assign in_take    = i_in_valid && !o_in_stall;

    assign hash_start = r_mid ? r_hash : ((r_seed == '0) ? FNV_PRIME : r_seed);

    // Multiply by 0x01000193 as a sum of shifted copies, then XOR in the sign-extended byte.
    assign n_hash = ((hash_start << 24) + (hash_start << 8) + (hash_start << 7)
                     + (hash_start << 4) + (hash_start << 1) + hash_start)
                    ^ {{(HASH_W - BYTE_W){r_a_byte[BYTE_W-1]}}, r_a_byte};

    sshf_fold u_fold (
        .i_hash      (n_hash),
        .i_fold_bits (r_fold_bits),
        .o_folded    (folded)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_byte <= i_data_byte;
            r_a_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
            r_mid  <= 1'b0;
        end else if (a_move) begin
            r_hash <= n_hash;
            r_mid  <= !r_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_move && r_a_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move && r_a_last) begin
            r_full   <= n_hash;
            r_folded <= folded;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_full_hash   = r_full;
    assign o_folded_hash = r_folded;

    // The input side stalls only behind a last byte blocked by a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_a_last && r_out_valid && i_out_stall))
        else $error("input stall without a blocked last byte");

    // A finished string always makes the next byte start from the seed, or FNV_PRIME if the seed is 0.
    a_string_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_move && r_a_last) |=> !r_mid)
        else $error("string still open after its last byte");

    // A byte that does not end the string never produces a result.
    a_no_mid_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_move && !r_a_last && r_out_valid && !i_out_stall) |=> !r_out_valid)
        else $error("result produced by a byte that is not last");

    // For fold_bits of 1 to 32, the folded value has no bits at or above the configured width.
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_move && r_a_last && r_fold_bits != '0 && r_fold_bits <= t_fold_bits'(HASH_W))
        |=> ((o_folded_hash >> $past(r_fold_bits)) == '0))
        else $error("folded hash wider than fold_bits");

endmodule

// File: hw/rtl/sshf_fold.sv
`timescale 1ns / 1ps

module sshf_fold (
    input  sshf_pkg::t_hash      i_hash,
    input  sshf_pkg::t_fold_bits i_fold_bits,
    output sshf_pkg::t_hash      o_folded
);
    import sshf_pkg::*;

    t_fold_bits bits;
    t_fold_bits width;
    t_fold_bits rest;
    t_hash      h;
    t_hash      rest_mask;

    // Clamp the width to 1..32 as the register may hold 0 or 33..63.
    always_comb begin
        if (i_fold_bits == '0) begin
            bits = t_fold_bits'(1);
        end else if (i_fold_bits > t_fold_bits'(HASH_W)) begin
            bits = t_fold_bits'(HASH_W);
        end else begin
            bits = i_fold_bits;
        end
    end

    // Halve the word while the target is narrower than the current half,
    // then XOR the top bits of what remains onto the bottom.
    always_comb begin
        h     = i_hash;
        width = t_fold_bits'(FOLD_START);
        for (int k = 0; k < 4; k++) begin
            if (bits < t_fold_bits'(FOLD_START >> k)) begin
                h = (h >> (FOLD_START >> k))
                    ^ (h & ((t_hash'(1) << (FOLD_START >> k)) - t_hash'(1)));
                width = t_fold_bits'(FOLD_START >> (k + 1));
            end
        end
        rest      = (width << 1) - bits;
        rest_mask = (t_hash'(1) << rest) - t_hash'(1);
        o_folded  = (h >> rest) ^ (h & rest_mask);
    end

endmodule

// File: test/seeded_string_hash_fold_tb.sv
`timescale 1ns / 1ps

module seeded_string_hash_fold_tb;
    import sshf_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        t_hash full;
        t_hash folded;
    } t_hash_pair;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [BYTE_W-1:0] i_data_byte;
    logic        i_last;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_hash       o_full_hash;
    t_hash       o_folded_hash;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the block's state and registers.
    t_hash      hash_acc;
    logic       in_string;
    t_hash      seed_shadow;
    t_fold_bits fold_shadow;

    t_hash_pair pending_hashes[$];
    t_hash_pair want;
    int         mismatch_count = 0;
    int         cycle_count = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req_len = 0;
    int hold_req_id = 0;
    int hold_seen_id = 0;
    int hold_left = 0;

    seeded_string_hash_fold uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_full_hash   (o_full_hash),
        .o_folded_hash (o_folded_hash),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [63:0] low_bits(input int n);
        return (n >= 32) ? 64'hffff_ffff : ((64'd1 << n) - 64'd1);
    endfunction

    // Halve the working width until the requested width fits, then fold the remainder.
    function automatic t_hash fold_hash(input t_hash h, input t_fold_bits fb);
        int bits;
        int width;
        int rest;
        logic [63:0] v;
        bits = fb;
        if (bits < 1) bits = 1;
        if (bits > 32) bits = 32;
        width = FOLD_START;
        v = {32'd0, h};
        while (bits < width) begin
            v = (v >> width) ^ (v & low_bits(width));
            width = width / 2;
        end
        rest = 2 * width - bits;
        v = (v >> rest) ^ (v & low_bits(rest));
        return v[31:0];
    endfunction

    task automatic hash_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        t_hash start;
        t_hash h;
        t_hash_pair p;
        start = in_string ? hash_acc : ((seed_shadow == '0) ? FNV_PRIME : seed_shadow);
        h = (start * FNV_PRIME) ^ {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
        hash_acc = h;
        in_string = !is_last;
        if (is_last) begin
            p.full = h;
            p.folded = fold_hash(h, fold_shadow);
            pending_hashes = {pending_hashes, p};
        end
    endtask

    task automatic report_mismatch(input string what, input t_hash got, input t_hash exp_val);
        $display("error at %0t: %s: got %h, wanted %h", $realtime, what, got, exp_val);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("seeded_string_hash_fold: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_hashes.size() == 0) begin
                    report_mismatch("result transfer with nothing pending", o_full_hash, '0);
                end else begin
                    want = pending_hashes.pop_front();
                    if (o_full_hash !== want.full)
                        report_mismatch("full_hash", o_full_hash, want.full);
                    if (o_folded_hash !== want.folded)
                        report_mismatch("folded_hash", o_folded_hash, want.folded);
                end
            end
            if (i_in_valid && !o_in_stall) hash_byte(i_data_byte, i_last);
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_req_id != hold_seen_id) begin
            hold_seen_id = hold_req_id;
            hold_left = hold_req_len;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_last <= is_last;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop offering bytes and wait until every pending result has been transferred.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_addr idx, input logic [31:0] value);
        drain_results();
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_SEED) seed_shadow = value;
        else fold_shadow = value[FOLD_W-1:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_config();
        logic [31:0] s;
        logic [31:0] f;
        case ($urandom_range(3))
            0: s = 32'd0;
            1: s = 32'hffff_ffff;
            default: s = $urandom;
        endcase
        case ($urandom_range(5))
            0: f = 32'd0;
            1: f = 32'd1;
            2: f = 32'd32;
            3: f = 32'd63;
            default: f = $urandom_range(63);
        endcase
        // Bits above the register width should be dropped.
        if ($urandom_range(3) == 0) f = f | ($urandom & 32'hffff_ffc0);
        write_reg(REG_SEED, s);
        write_reg(REG_FOLD_BITS, f);
    endtask

    task automatic random_strings(input int n_bytes);
        int sent;
        int len;
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
            if (len > n_bytes - sent) len = n_bytes - sent;
            for (int k = 0; k < len; k++) begin
                send_byte(BYTE_W'($urandom_range(255)), k == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h7f, 1'b1);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_fold_widths();
        write_reg(REG_SEED, 32'hffff_ffff);
        write_reg(REG_FOLD_BITS, 32'd1);
        // Zero bytes inside a string do not end it.
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        write_reg(REG_SEED, 32'h1234_5678);
        write_reg(REG_FOLD_BITS, 32'd0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b1);
        write_reg(REG_FOLD_BITS, 32'hffff_ffff);
        send_byte(8'h3c, 1'b1);
        write_reg(REG_FOLD_BITS, 32'd33);
        send_byte(8'hc3, 1'b1);
        write_reg(REG_FOLD_BITS, 32'd16);
        send_byte(8'h01, 1'b1);
        write_reg(REG_FOLD_BITS, 32'd17);
        send_byte(8'hfe, 1'b1);
        write_reg(REG_FOLD_BITS, 32'd31);
        send_byte(8'h7e, 1'b1);
    endtask

    // Seed is only taken at the start of a string and fold_bits only on its last byte.
    task automatic test_write_mid_string();
        write_reg(REG_SEED, 32'hdead_beef);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        write_reg(REG_SEED, 32'h0000_0001);
        write_reg(REG_FOLD_BITS, 32'd5);
        send_byte(8'h43, 1'b1);
        send_byte(8'h44, 1'b1);
        drain_results();
    endtask

    task automatic test_output_hold();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_config();
        hold_req_len = 80;
        hold_req_id = hold_req_id + 1;
        for (int k = 0; k < 30; k++) begin
            send_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
        send_byte(BYTE_W'($urandom_range(255)), 1'b1);
        drain_results();
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_bytes);
        int done;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < n_bytes) begin
            random_config();
            random_strings(25);
            done += 25;
        end
        drain_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_data_byte = '0;
        i_last = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hash_acc = '0;
        in_string = 1'b0;
        seed_shadow = '0;
        fold_shadow = FOLD_RESET;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_fold_widths();
        test_write_mid_string();
        test_output_hold();
        run_random_phase(0, 0, 125);
        run_random_phase(86, 0, 125);
        run_random_phase(0, 86, 125);
        run_random_phase(19, 19, 125);

        drain_results();
        if (mismatch_count == 0) begin
            $display("seeded_string_hash_fold: match");
        end else begin
            $display("seeded_string_hash_fold: mismatch");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/sshf_pkg.sv
hw/rtl/sshf_fold.sv
hw/rtl/seeded_string_hash_fold.sv
test/seeded_string_hash_fold_tb.sv
